FILE: design/bilinear_texture_sampler_macros.svh
// assertion macros shared by the sampler rtl
// no dependencies; included by the files that assert
`ifndef BILINEAR_TEXTURE_SAMPLER_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_MACROS_SVH

// plain property checked every clock outside reset
`define BTS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define BTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bts_pkg.sv
// shared constants for the bilinear texture sampler
// no dependencies
`default_nettype none
package bts_pkg;
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int QUEUE_DEPTH    = 4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 2'd1;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic [16:0] COORD_ONE   = 17'h10000;
	localparam logic [8:0]  WEIGHT_ONE  = 9'd256;
	localparam logic [23:0] ROUND_HALF  = 24'h008000;
endpackage
`default_nettype wire

FILE: design/bts_queue.sv
// small first-in first-out queue between the front and back ends
// uses bts_pkg and the sampler assertion macros
`default_nettype none
`include "bilinear_texture_sampler_macros.svh"
module bts_queue import bts_pkg::*; #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  wire logic [W-1:0] push_data,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output logic [W-1:0]      pop_data
);
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	logic [W-1:0]  slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push_fire, pop_fire;

	assign push_ready = (cnt_q != FULL_CNT);
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_fire) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_fire) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop_fire)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push_fire && !pop_fire) cnt_q <= cnt_q + 1'b1;
			else if (pop_fire && !push_fire) cnt_q <= cnt_q - 1'b1;
		end
	end

	`BTS_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= FULL_CNT, "queue count above depth")
	`BTS_ASSERT_NEXT(a_cnt_inc, clk, arst_n, push_fire && !pop_fire, cnt_q == $past(cnt_q) + 1'b1, "queue count did not grow on push")
	`BTS_ASSERT_NEXT(a_drain, clk, arst_n, pop_fire && !push_fire && cnt_q == CW'(1), !pop_valid, "queue not empty after last pop")
endmodule
`default_nettype wire

FILE: design/bts_front.sv
// front end: config registers, input transfer, coordinate scaling, classification
// uses bts_pkg; feeds bts_queue
`default_nettype none
module bts_front import bts_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int CMD_W      = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  kind,
	input  wire logic [16:0]           tex_s,
	input  wire logic [16:0]           tex_t,
	input  wire logic [7:0]            texel_x,
	input  wire logic [7:0]            texel_y,
	input  wire logic [7:0]            red_in,
	input  wire logic [7:0]            green_in,
	input  wire logic [7:0]            blue_in,
	output logic                       q_valid,
	input  wire logic                  q_ready,
	output logic [CMD_W-1:0]           q_data
);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam logic [CFG_DATA_W-1:0] W_RST = CFG_DATA_W'(MAX_WIDTH > 511 ? 511 : MAX_WIDTH);
	localparam logic [CFG_DATA_W-1:0] H_RST = CFG_DATA_W'(MAX_HEIGHT > 511 ? 511 : MAX_HEIGHT);

	typedef struct packed {
		logic          is_sample;
		logic [XW-1:0] col;
		logic [YW-1:0] row;
		logic          step_x;
		logic          step_y;
		logic [7:0]    fu;
		logic [7:0]    fv;
		logic [23:0]   rgb;
	} cmd_t;

	logic [CFG_DATA_W-1:0] width_q, height_q;
	logic [31:0] wl, hl, w_eff, h_eff, xl, yl;
	logic [XW-1:0] w_m1;
	logic [YW-1:0] h_m1;
	logic [16:0] s_c, t_c, t_inv;
	logic wr_ok, take;

	logic              vld_s1, samp_s1;
	logic [XW+16:0]    u_s1;
	logic [YW+16:0]    v_s1;
	logic [XW-1:0]     wm1_s1, colw_s1, iu;
	logic [YW-1:0]     hm1_s1, roww_s1, iv;
	logic [23:0]       rgb_s1;
	cmd_t              cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= W_RST;
			height_q <= H_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TEX_WIDTH:  width_q  <= cfg_data;
				REG_TEX_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		wl = 32'(width_q);
		hl = 32'(height_q);
		w_eff = (wl == 0) ? 32'd1 : ((wl > MAX_WIDTH) ? 32'(MAX_WIDTH) : wl);
		h_eff = (hl == 0) ? 32'd1 : ((hl > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : hl);
		w_m1 = XW'(w_eff - 32'd1);
		h_m1 = YW'(h_eff - 32'd1);
		s_c = (tex_s > COORD_ONE) ? COORD_ONE : tex_s;
		t_c = (tex_t > COORD_ONE) ? COORD_ONE : tex_t;
		t_inv = COORD_ONE - t_c;
		xl = 32'(texel_x);
		yl = 32'(texel_y);
		wr_ok = (xl < MAX_WIDTH) && (yl < MAX_HEIGHT);
	end

	assign in_ready = !vld_s1 || q_ready;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			// out-of-range writes are taken and dropped here
			vld_s1 <= in_valid && (kind == KIND_SAMPLE || wr_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			samp_s1 <= (kind == KIND_SAMPLE);
			u_s1    <= (XW+17)'(w_m1) * (XW+17)'(s_c);
			v_s1    <= (YW+17)'(h_m1) * (YW+17)'(t_inv);
			wm1_s1  <= w_m1;
			hm1_s1  <= h_m1;
			colw_s1 <= xl[XW-1:0];
			roww_s1 <= yl[YW-1:0];
			rgb_s1  <= {red_in, green_in, blue_in};
		end
	end

	always_comb begin
		iu = u_s1[XW+15:16];
		iv = v_s1[YW+15:16];
		cmd.is_sample = samp_s1;
		cmd.col    = samp_s1 ? iu : colw_s1;
		cmd.row    = samp_s1 ? iv : roww_s1;
		cmd.step_x = (iu < wm1_s1);
		cmd.step_y = (iv < hm1_s1);
		cmd.fu     = u_s1[15:8];
		cmd.fv     = v_s1[15:8];
		cmd.rgb    = rgb_s1;
	end

	assign q_valid = vld_s1;
	assign q_data  = CMD_W'(cmd);
endmodule
`default_nettype wire

FILE: design/bts_back.sv
// back end: four parity banks of texels, fetch and bilinear blend pipeline
// uses bts_pkg; fed by bts_queue
`default_nettype none
module bts_back import bts_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int CMD_W      = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	output logic                  q_ready,
	input  wire logic [CMD_W-1:0] q_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            red_out,
	output logic [7:0]            green_out,
	output logic [7:0]            blue_out
);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int HALF_W = MAX_WIDTH / 2 + 1;
	localparam int HALF_H = MAX_HEIGHT / 2 + 1;
	localparam int BANK_DEPTH = HALF_W * HALF_H;
	localparam int AW = $clog2(BANK_DEPTH);

	typedef struct packed {
		logic          is_sample;
		logic [XW-1:0] col;
		logic [YW-1:0] row;
		logic          step_x;
		logic          step_y;
		logic [7:0]    fu;
		logic [7:0]    fv;
		logic [23:0]   rgb;
	} cmd_t;

	cmd_t cmd;
	logic adv, pop;
	logic [AW-1:0] raddr [4];
	logic [AW-1:0] waddr;
	logic [XW:0]   col_w;
	logic [YW:0]   row_w;
	logic [1:0]    wbank;
	logic [23:0]   rd_q [4];

	logic       vld_b1, px_b1, py_b1, stx_b1, sty_b1;
	logic [7:0] fu_b1, fv_b1;
	logic       vld_b2;
	logic [23:0] tex_b2 [4];
	logic [16:0] wt_b2 [4];
	logic [1:0]  sel [4];
	logic [8:0]  fu_n, fv_n, fu_e, fv_e;
	logic [23:0] acc [3];

	assign cmd     = cmd_t'(q_data);
	assign adv     = !out_valid || out_ready;
	assign q_ready = adv;
	assign pop     = q_valid && adv;

	always_comb begin
		logic [XW:0] cp;
		logic [YW:0] rp;
		for (int b = 0; b < 4; b++) begin
			// bank b holds column parity b[0] and row parity b[1]
			cp = (cmd.col[0] == b[0]) ? {1'b0, cmd.col} : {1'b0, cmd.col} + 1'b1;
			rp = (cmd.row[0] == b[1]) ? {1'b0, cmd.row} : {1'b0, cmd.row} + 1'b1;
			raddr[b] = AW'(32'(rp[YW:1]) * HALF_W + 32'(cp[XW:1]));
		end
		col_w = {1'b0, cmd.col};
		row_w = {1'b0, cmd.row};
		waddr = AW'(32'(row_w[YW:1]) * HALF_W + 32'(col_w[XW:1]));
		wbank = {cmd.row[0], cmd.col[0]};
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [23:0] mem [BANK_DEPTH];
		always_ff @(posedge clk) begin
			if (pop && !cmd.is_sample && wbank == 2'(b)) begin
				mem[waddr] <= cmd.rgb;
			end
			if (adv) begin
				rd_q[b] <= mem[raddr[b]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_b1    <= 1'b0;
			vld_b2    <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_b1    <= pop && cmd.is_sample;
			vld_b2    <= vld_b1;
			out_valid <= vld_b2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_b1  <= cmd.col[0];
			py_b1  <= cmd.row[0];
			stx_b1 <= cmd.step_x;
			sty_b1 <= cmd.step_y;
			fu_b1  <= cmd.fu;
			fv_b1  <= cmd.fv;
		end
	end

	always_comb begin
		// a clamped neighbour reads the same bank as its base texel
		sel[0] = {py_b1, px_b1};
		sel[1] = {py_b1, px_b1 ^ stx_b1};
		sel[2] = {py_b1 ^ sty_b1, px_b1};
		sel[3] = {py_b1 ^ sty_b1, px_b1 ^ stx_b1};
		fu_e = {1'b0, fu_b1};
		fv_e = {1'b0, fv_b1};
		fu_n = WEIGHT_ONE - fu_e;
		fv_n = WEIGHT_ONE - fv_e;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) tex_b2[k] <= rd_q[sel[k]];
			wt_b2[0] <= 17'(18'(fu_n) * 18'(fv_n));
			wt_b2[1] <= 17'(18'(fu_e) * 18'(fv_n));
			wt_b2[2] <= 17'(18'(fu_n) * 18'(fv_e));
			wt_b2[3] <= 17'(18'(fu_e) * 18'(fv_e));
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			acc[ch] = ROUND_HALF;
			for (int k = 0; k < 4; k++) begin
				acc[ch] = acc[ch] + 24'(25'(tex_b2[k][16-8*ch +: 8]) * 25'(wt_b2[k]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_out   <= acc[0][23:16];
			green_out <= acc[1][23:16];
			blue_out  <= acc[2][23:16];
		end
	end
endmodule
`default_nettype wire

FILE: design/bilinear_texture_sampler.sv
// top level of the bilinear texture sampler: front end, queue, back end
// uses bts_pkg, bts_front, bts_queue, bts_back
//
// channel  | handshake            | payload
// cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
// in       | in_valid/in_ready    | kind, tex_s, tex_t, texel_x, texel_y, red/green/blue_in
// out      | out_valid/out_ready  | red_out, green_out, blue_out
//
// one item per cycle sustained while out_ready does not stall; a sample result is registered
// through these steps in order: scale multiply, queue, bank read, weight multiply, blend adder tree
// texel writes give no result and land in one of four x/y parity banks
// reset clears control state only; texel contents stay undefined until written
// an output stall halts the back end; the front keeps filling the four-entry queue
`default_nettype none
module bilinear_texture_sampler import bts_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  kind,
	input  wire logic [16:0]           tex_s,
	input  wire logic [16:0]           tex_t,
	input  wire logic [7:0]            texel_x,
	input  wire logic [7:0]            texel_y,
	input  wire logic [7:0]            red_in,
	input  wire logic [7:0]            green_in,
	input  wire logic [7:0]            blue_in,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 red_out,
	output logic [7:0]                 green_out,
	output logic [7:0]                 blue_out
);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int CMD_W = 1 + XW + YW + 2 + 16 + 24;

	logic             fq_valid, fq_ready, qb_valid, qb_ready;
	logic [CMD_W-1:0] fq_data, qb_data;

	bts_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .CMD_W(CMD_W)) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .tex_s(tex_s), .tex_t(tex_t),
		.texel_x(texel_x), .texel_y(texel_y),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
	);

	bts_queue #(.W(CMD_W)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(fq_valid), .push_ready(fq_ready), .push_data(fq_data),
		.pop_valid(qb_valid), .pop_ready(qb_ready), .pop_data(qb_data)
	);

	bts_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .CMD_W(CMD_W)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out)
	);
endmodule
`default_nettype wire

FILE: verif/bts_checker.sv
// checker for the bilinear texture sampler: tracks register and texel transfers,
// predicts each filtered color and compares it with the output channel
// depends on bts_pkg
`timescale 1ns / 1ps
module bts_checker import bts_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire logic                  kind,
	input  wire logic [16:0]           tex_s,
	input  wire logic [16:0]           tex_t,
	input  wire logic [7:0]            texel_x,
	input  wire logic [7:0]            texel_y,
	input  wire logic [7:0]            red_in,
	input  wire logic [7:0]            green_in,
	input  wire logic [7:0]            blue_in,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire logic [7:0]            red_out,
	input  wire logic [7:0]            green_out,
	input  wire logic [7:0]            blue_out,
	output int                         colors_pending,
	output int                         fail_count
);
	logic [23:0] texels [0:65535];
	logic [8:0]  width_reg;
	logic [8:0]  height_reg;
	logic [23:0] color_queue [$];

	function automatic int used_size(input logic [8:0] r, input int maxv);
		if (r == 0)
			return 1;
		if (r > maxv)
			return maxv;
		return r;
	endfunction

	function automatic logic [23:0] filter_color(input logic [16:0] s_in, input logic [16:0] t_in);
		int w, h, s, t, iu, iv, un, vn, fu, fv, acc, k, ch;
		longint u, v;
		int wt [4];
		logic [23:0] px [4];
		logic [23:0] rgb;
		w = used_size(width_reg, DEF_MAX_WIDTH);
		h = used_size(height_reg, DEF_MAX_HEIGHT);
		s = (s_in > COORD_ONE) ? COORD_ONE : s_in;
		t = (t_in > COORD_ONE) ? COORD_ONE : t_in;
		u = longint'(w - 1) * s;
		v = longint'(h - 1) * (COORD_ONE - t);
		iu = int'(u >> 16);
		iv = int'(v >> 16);
		fu = int'((u >> 8) & 255);
		fv = int'((v >> 8) & 255);
		un = (iu + 1 <= w - 1) ? iu + 1 : iu;
		vn = (iv + 1 <= h - 1) ? iv + 1 : iv;
		px[0] = texels[iv * DEF_MAX_WIDTH + iu];
		px[1] = texels[iv * DEF_MAX_WIDTH + un];
		px[2] = texels[vn * DEF_MAX_WIDTH + iu];
		px[3] = texels[vn * DEF_MAX_WIDTH + un];
		wt[0] = (256 - fu) * (256 - fv);
		wt[1] = fu * (256 - fv);
		wt[2] = (256 - fu) * fv;
		wt[3] = fu * fv;
		for (ch = 0; ch < 3; ch++) begin
			acc = 32768;
			for (k = 0; k < 4; k++)
				acc += ((px[k] >> (16 - 8 * ch)) & 8'hff) * wt[k];
			rgb[16 - 8 * ch +: 8] = 8'(acc >> 16);
		end
		return rgb;
	endfunction

	initial
		fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		logic [23:0] want;
		if (!arst_n) begin
			width_reg = 9'(DEF_MAX_WIDTH);
			height_reg = 9'(DEF_MAX_HEIGHT);
			color_queue.delete();
		end else begin
			// result transfer is checked before this edge's input transfer is predicted
			if (out_valid && out_ready) begin
				if (color_queue.size() == 0) begin
					$display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
						red_out, green_out, blue_out);
					fail_count++;
				end else begin
					want = color_queue.pop_front();
					if (red_out !== want[23:16]) begin
						$display("%0t: red mismatch expected %0d actual %0d", $time,
							want[23:16], red_out);
						fail_count++;
					end
					if (green_out !== want[15:8]) begin
						$display("%0t: green mismatch expected %0d actual %0d", $time,
							want[15:8], green_out);
						fail_count++;
					end
					if (blue_out !== want[7:0]) begin
						$display("%0t: blue mismatch expected %0d actual %0d", $time,
							want[7:0], blue_out);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TEX_WIDTH)
					width_reg = cfg_data;
				else if (cfg_index == REG_TEX_HEIGHT)
					height_reg = cfg_data;
			end
			if (in_valid && in_ready) begin
				if (kind == KIND_WRITE)
					texels[texel_y * DEF_MAX_WIDTH + texel_x] = {red_in, green_in, blue_in};
				else
					color_queue.push_back(filter_color(tex_s, tex_t));
			end
		end
		colors_pending = color_queue.size();
	end
endmodule

FILE: verif/tb_top.sv
// top of the sampler testbench: clock, reset, register and texel stimulus, verdict
// depends on bts_pkg, bilinear_texture_sampler and bts_checker
`timescale 1ns / 1ps
module tb_top;
	import bts_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  kind;
	logic [16:0]           tex_s;
	logic [16:0]           tex_t;
	logic [7:0]            texel_x;
	logic [7:0]            texel_y;
	logic [7:0]            red_in;
	logic [7:0]            green_in;
	logic [7:0]            blue_in;
	logic                  out_valid;
	logic                  out_ready;
	logic [7:0]            red_out;
	logic [7:0]            green_out;
	logic [7:0]            blue_out;
	int                    colors_pending;
	int                    fail_count;

	logic        steady;
	bit          written [0:65535];
	logic [8:0]  width_set;
	logic [8:0]  height_set;

	bilinear_texture_sampler dut (.*);
	bts_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		out_ready <= steady || ($urandom_range(99) >= 19);

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic push_item(input logic k, input logic [16:0] s, input logic [16:0] t,
			input logic [7:0] x, input logic [7:0] y, input logic [23:0] rgb);
		if (!steady && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		tex_s <= s;
		tex_t <= t;
		texel_x <= x;
		texel_y <= y;
		{red_in, green_in, blue_in} <= rgb;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic put_texel(input logic [7:0] x, input logic [7:0] y, input logic [23:0] rgb);
		written[y * DEF_MAX_WIDTH + x] = 1'b1;
		push_item(KIND_WRITE, 17'($urandom), 17'($urandom), x, y, rgb);
	endtask

	function automatic int used_size(input logic [8:0] r, input int maxv);
		if (r == 0)
			return 1;
		if (r > maxv)
			return maxv;
		return r;
	endfunction

	// writes any unwritten texel of the footprint first, so no read hits an empty entry
	task automatic sample_at(input logic [16:0] s_in, input logic [16:0] t_in);
		int w, h, s, t, iu, iv, un, vn, k;
		int cols [4];
		int rows [4];
		w = used_size(width_set, DEF_MAX_WIDTH);
		h = used_size(height_set, DEF_MAX_HEIGHT);
		s = (s_in > COORD_ONE) ? COORD_ONE : s_in;
		t = (t_in > COORD_ONE) ? COORD_ONE : t_in;
		iu = int'((longint'(w - 1) * s) >> 16);
		iv = int'((longint'(h - 1) * (COORD_ONE - t)) >> 16);
		un = (iu + 1 <= w - 1) ? iu + 1 : iu;
		vn = (iv + 1 <= h - 1) ? iv + 1 : iv;
		cols = '{iu, un, iu, un};
		rows = '{iv, iv, vn, vn};
		for (k = 0; k < 4; k++)
			if (!written[rows[k] * DEF_MAX_WIDTH + cols[k]])
				put_texel(8'(cols[k]), 8'(rows[k]), 24'($urandom));
		push_item(KIND_SAMPLE, s_in, t_in, 8'($urandom), 8'($urandom), 24'($urandom));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (colors_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_TEX_WIDTH)
			width_set = val;
		else if (idx == REG_TEX_HEIGHT)
			height_set = val;
	endtask

	function automatic logic [16:0] pick_coord();
		case ($urandom_range(9))
			0: return 17'd0;
			1: return COORD_ONE;
			2: return 17'($urandom_range(131071, 65537));
			default: return 17'($urandom_range(65536));
		endcase
	endfunction

	task automatic random_items(input int count);
		int n, w, h;
		w = used_size(width_set, DEF_MAX_WIDTH);
		h = used_size(height_set, DEF_MAX_HEIGHT);
		for (n = 0; n < count; n++) begin
			if ($urandom_range(99) < 45) begin
				if ($urandom_range(1))
					put_texel(8'($urandom_range(w - 1)), 8'($urandom_range(h - 1)),
						24'($urandom));
				else
					put_texel(8'($urandom), 8'($urandom), 24'($urandom));
			end else begin
				sample_at(pick_coord(), pick_coord());
			end
		end
	endtask

	initial begin
		int p;
		int widths [8]  = '{0, 1, 2, 511, 256, 1, 17, 300};
		int heights [8] = '{0, 1, 3, 511, 1, 256, 9, 2};
		clk = 1'b0;
		arst_n = 1'b0;
		steady = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TEX_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_WRITE;
		tex_s = '0;
		tex_t = '0;
		texel_x = '0;
		texel_y = '0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		out_ready = 1'b0;
		width_set = 9'(DEF_MAX_WIDTH);
		height_set = 9'(DEF_MAX_HEIGHT);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corners, edge coordinates, saturation, half-way blends
		put_texel(8'd0, 8'd0, 24'h000000);
		put_texel(8'd255, 8'd255, 24'hffffff);
		put_texel(8'd1, 8'd0, 24'hff00ff);
		put_texel(8'd0, 8'd1, 24'h00ff00);
		put_texel(8'd1, 8'd1, 24'hffffff);
		sample_at(17'd0, COORD_ONE);
		sample_at(COORD_ONE, 17'd0);
		sample_at(17'h1ffff, 17'h1ffff);
		sample_at(17'd0, 17'd0);
		sample_at(COORD_ONE, COORD_ONE);
		sample_at(17'd128, 17'd65408);
		sample_at(17'd32768, 17'd32768);
		sample_at(17'd65535, 17'd1);
		sample_at(17'd257, 17'd65279);
		random_items(150);

		for (p = 0; p < 8; p++) begin
			write_reg(REG_TEX_WIDTH, 9'(widths[p]));
			write_reg(REG_TEX_HEIGHT, 9'(heights[p]));
			if (p == 2) begin
				write_reg(REG_SPARE_A, 9'h1ff);
				write_reg(REG_SPARE_B, 9'h000);
			end
			steady = (p == 4);
			sample_at(17'd0, 17'd0);
			sample_at(COORD_ONE, 17'd0);
			random_items(150);
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		@(posedge clk);
		while (colors_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
